// ===== design/mcal_pkg.sv =====
// Shared types, constants and tables for the magnetometer calibration unit.
// Used by the front end, the job queue, the back end and the top level.
// Depends on nothing else.
package mcal_pkg;

  // Valid samples averaged into one result (1 to 16).
  localparam int unsigned SAMPLES = 4;

  localparam int unsigned NumAxes = 3;
  localparam int unsigned RawW    = 16;
  localparam int unsigned SumW    = 21;
  localparam int unsigned GposW   = 4;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned BiasW   = 24;
  localparam int unsigned RowW    = 48;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned CorrW   = 26;
  localparam int unsigned MeanW   = 30;
  localparam int unsigned ProdW   = 42;
  localparam int unsigned AccW    = 43;
  localparam int unsigned FieldW  = 29;
  localparam int unsigned DataInW = 128;
  localparam int unsigned DataOutW = 152;

  // The group counter wraps at sixteen, so the end mark is taken modulo sixteen.
  localparam logic [GposW-1:0] GroupEnd = GposW'(SAMPLES % 16);

  // Division of the running sum by SAMPLES: an offset makes the sum
  // non-negative, a reciprocal multiply gives the quotient and a small
  // table turns the remainder into the eight fraction bits.
  localparam int unsigned AoffW      = 25;
  localparam int unsigned QuotW      = 21;
  localparam int unsigned RemW       = 4;
  localparam int unsigned FracW      = 8;
  localparam int unsigned RecipW     = 30;
  localparam int unsigned RecipShift = 29;
  localparam int unsigned DivProdW   = AoffW + RecipW;
  localparam logic [RecipW-1:0] RecipMult =
    RecipW'(((64'd1 << RecipShift) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
  localparam logic [AoffW-1:0] SumOffset  = AoffW'(64'(SAMPLES) << 20);
  localparam logic [AoffW-1:0] SamplesW   = AoffW'(SAMPLES);
  localparam logic signed [MeanW-1:0] MeanOffset = 30'sd268435456;

  function automatic logic [15:0][FracW-1:0] build_frac_lut();
    logic [15:0][FracW-1:0] lut;
    for (int r = 0; r < 16; r++) begin
      lut[r] = FracW'((256 * r) / SAMPLES);
    end
    return lut;
  endfunction

  localparam logic [15:0][FracW-1:0] FracLut = build_frac_lut();

  // Rounding and output saturation of the matrix product.
  localparam int unsigned RoundShift = 13;
  localparam logic signed [AccW-1:0] RoundHalf = 43'sd4096;
  localparam logic signed [AccW-1:0] FieldHi   = 43'sd268435455;
  localparam logic signed [AccW-1:0] FieldLo   = -43'sd268435456;

  // Job queue between the front and the back end.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QptrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QcntW      = $clog2(QueueDepth + 1);

  // Mounting orientation, output (x, y, z) taken from the raw axes.
  typedef enum logic [2:0] {
    ORIENT_X_Y_Z    = 3'd0,
    ORIENT_NY_X_Z   = 3'd1,
    ORIENT_NX_NY_Z  = 3'd2,
    ORIENT_Y_NX_Z   = 3'd3,
    ORIENT_X_NY_NZ  = 3'd4,
    ORIENT_Y_X_NZ   = 3'd5,
    ORIENT_NX_Y_NZ  = 3'd6,
    ORIENT_NY_NX_NZ = 3'd7
  } orient_e;

  typedef enum logic [2:0] {
    CFG_ORIENT   = 3'd0,
    CFG_BIAS_X   = 3'd1,
    CFG_BIAS_Y   = 3'd2,
    CFG_BIAS_Z   = 3'd3,
    CFG_ROW_ZERO = 3'd4,
    CFG_ROW_ONE  = 3'd5,
    CFG_ROW_TWO  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_MAT,
    BK_EMIT
  } back_state_e;

  typedef struct packed {
    orient_e                           orientation;
    logic [NumAxes-1:0][BiasW-1:0]     bias;
    logic [NumAxes-1:0][RowW-1:0]      matrix;
  } cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]                  time_stamp;
    logic [NumAxes-1:0][SumW-1:0]      sums;
  } job_t;

  typedef struct packed {
    logic [TimeW-1:0]  time_stamp;
    logic [FieldW-1:0] field_x;
    logic [FieldW-1:0] field_y;
    logic [FieldW-1:0] field_z;
  } result_t;

  localparam logic [NumAxes-1:0][RowW-1:0] MatrixReset = {
    48'd35184372088832, 48'd536870912, 48'd8192
  };

endpackage

// ===== design/mcal_front.sv =====
// Front end: checks each read, applies the mounting orientation and keeps the
// running axis sums; a finished group is pushed to the job queue.
// Depends on mcal_pkg.
module mcal_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_ok_i,
  input  logic [mcal_pkg::DataInW-1:0] in_data_i,
  input  mcal_pkg::orient_e           orientation_i,
  input  logic                        queue_full_i,
  output logic                        push_o,
  output mcal_pkg::job_t              job_o
);
  import mcal_pkg::*;

  logic [GposW-1:0]        gpos_q, gpos_d, gpos_inc;
  logic signed [SumW-1:0]  sum_q [NumAxes];
  logic signed [SumW-1:0]  sum_new [NumAxes];
  logic signed [RawW-1:0]  raw_x, raw_y, raw_z;
  logic signed [RawW-1:0]  vec [NumAxes];
  logic                    good, take, last;

  function automatic logic signed [RawW-1:0] neg_sat(logic signed [RawW-1:0] v);
    return (v == 16'sh8000) ? 16'sh7FFF : -v;
  endfunction

  assign raw_x = {in_data_i[23:16], in_data_i[15:8]};
  assign raw_y = {in_data_i[39:32], in_data_i[31:24]};
  assign raw_z = {in_data_i[55:48], in_data_i[47:40]};

  // Transfer ok, data ready in the first status byte, no data error or overflow in the second.
  assign good = in_ok_i & in_data_i[0] & ~in_data_i[58] & ~in_data_i[59];

  assign in_ready_o = ~queue_full_i;
  assign take       = in_valid_i & in_ready_o & good;

  always_comb begin
    case (orientation_i)
      ORIENT_X_Y_Z: begin
        vec[0] = raw_x;          vec[1] = raw_y;          vec[2] = raw_z;
      end
      ORIENT_NY_X_Z: begin
        vec[0] = neg_sat(raw_y); vec[1] = raw_x;          vec[2] = raw_z;
      end
      ORIENT_NX_NY_Z: begin
        vec[0] = neg_sat(raw_x); vec[1] = neg_sat(raw_y); vec[2] = raw_z;
      end
      ORIENT_Y_NX_Z: begin
        vec[0] = raw_y;          vec[1] = neg_sat(raw_x); vec[2] = raw_z;
      end
      ORIENT_X_NY_NZ: begin
        vec[0] = raw_x;          vec[1] = neg_sat(raw_y); vec[2] = neg_sat(raw_z);
      end
      ORIENT_Y_X_NZ: begin
        vec[0] = raw_y;          vec[1] = raw_x;          vec[2] = neg_sat(raw_z);
      end
      ORIENT_NX_Y_NZ: begin
        vec[0] = neg_sat(raw_x); vec[1] = raw_y;          vec[2] = neg_sat(raw_z);
      end
      default: begin
        vec[0] = neg_sat(raw_y); vec[1] = neg_sat(raw_x); vec[2] = neg_sat(raw_z);
      end
    endcase
  end

  // The first sample of a group overwrites the sums.
  always_comb begin
    for (int k = 0; k < NumAxes; k++) begin
      sum_new[k] = (gpos_q == '0) ? SumW'(vec[k]) : sum_q[k] + SumW'(vec[k]);
    end
  end

  assign gpos_inc = gpos_q + GposW'(1);
  assign last     = (gpos_inc == GroupEnd);

  always_comb begin
    gpos_d = gpos_q;
    if (take) begin
      gpos_d = last ? '0 : gpos_inc;
    end
  end

  assign push_o = take & last;

  always_comb begin
    job_o.time_stamp = in_data_i[127:64];
    for (int k = 0; k < NumAxes; k++) begin
      job_o.sums[k] = sum_new[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gpos_q <= '0;
    end else begin
      gpos_q <= gpos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int k = 0; k < NumAxes; k++) begin
        sum_q[k] <= sum_new[k];
      end
    end
  end

endmodule

// ===== design/mcal_queue.sv =====
// Short first-in first-out queue of finished groups between the two ends.
// Depends on mcal_pkg.
module mcal_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mcal_pkg::job_t job_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output mcal_pkg::job_t job_o
);
  import mcal_pkg::*;

  job_t             slot_q [QueueDepth];
  logic [QptrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QcntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  function automatic logic [QptrW-1:0] ptr_next(logic [QptrW-1:0] p);
    return (p == QptrW'(QueueDepth - 1)) ? '0 : p + QptrW'(1);
  endfunction

  assign full_o  = (cnt_q == QcntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = slot_q[rd_q];

  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_d  = do_push ? ptr_next(wr_q) : wr_q;
    rd_d  = do_pop ? ptr_next(rd_q) : rd_q;
    cnt_d = cnt_q + QcntW'(do_push) - QcntW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= job_i;
    end
  end

endmodule

// ===== design/mcal_back.sv =====
// Back end: forms the mean of one group, removes the bias, applies the 3x3
// matrix on one shared multiplier and holds the result for the output side.
// Depends on mcal_pkg.
module mcal_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcal_pkg::cfg_t    cfg_i,
  input  logic              job_valid_i,
  input  mcal_pkg::job_t    job_i,
  output logic              pop_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output mcal_pkg::result_t res_o
);
  import mcal_pkg::*;

  back_state_e state_q, state_d;

  logic [1:0]               cnt_q, cnt_d;
  logic [1:0]               mrow_q, mrow_d, mcol_q, mcol_d;
  job_t                     job_q;
  logic [DivProdW-1:0]      prod_q, prod_d;
  logic signed [CorrW-1:0]  corr_q [NumAxes];
  logic signed [AccW-1:0]   acc_q, acc_d;
  logic signed [FieldW-1:0] fld_q [NumAxes];
  logic                     res_valid_q, res_valid_d;
  result_t                  res_q;

  logic div_mul, div_fin, mac_en, res_en, out_load, out_free;

  logic signed [SumW-1:0]   sum_mul, sum_fin;
  logic [AoffW-1:0]         aoff_mul, aoff_fin, rem_full;
  logic [QuotW-1:0]         quot;
  logic [RemW-1:0]          rem;
  logic signed [MeanW-1:0]  mean, corr_full;
  logic signed [BiasW-1:0]  bias_fin;
  logic [RowW-1:0]          row_sel;
  logic signed [CoefW-1:0]  coef;
  logic signed [ProdW-1:0]  mac_prod;
  logic signed [AccW-1:0]   rnd;
  logic signed [FieldW-1:0] fld_d;

  function automatic logic signed [SumW-1:0] pick_sum(job_t j, logic [1:0] k);
    case (k)
      2'd0:    return j.sums[0];
      2'd1:    return j.sums[1];
      2'd2:    return j.sums[2];
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [BiasW-1:0] pick_bias(cfg_t c, logic [1:0] k);
    case (k)
      2'd0:    return c.bias[0];
      2'd1:    return c.bias[1];
      2'd2:    return c.bias[2];
      default: return '0;
    endcase
  endfunction

  function automatic logic [RowW-1:0] pick_row(cfg_t c, logic [1:0] k);
    case (k)
      2'd0:    return c.matrix[0];
      2'd1:    return c.matrix[1];
      2'd2:    return c.matrix[2];
      default: return '0;
    endcase
  endfunction

  function automatic logic signed [CoefW-1:0] pick_coef(logic [RowW-1:0] w, logic [1:0] k);
    case (k)
      2'd0:    return w[15:0];
      2'd1:    return w[31:16];
      2'd2:    return w[47:32];
      default: return '0;
    endcase
  endfunction

  assign out_free = ~res_valid_q | res_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          state_d = BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_q == 2'(NumAxes)) begin
          state_d = BK_MAT;
        end
      end
      BK_MAT: begin
        if (mrow_q == 2'(NumAxes)) begin
          state_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    pop_o    = 1'b0;
    div_mul  = 1'b0;
    div_fin  = 1'b0;
    mac_en   = 1'b0;
    res_en   = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BK_IDLE: pop_o = job_valid_i;
      BK_DIV: begin
        div_mul = (cnt_q != 2'(NumAxes));
        div_fin = (cnt_q != '0);
      end
      BK_MAT: begin
        mac_en = (mrow_q != 2'(NumAxes));
        res_en = (mcol_q == '0) && (mrow_q != '0);
      end
      BK_EMIT: out_load = out_free;
      default: ;
    endcase
  end

  // Counters.
  always_comb begin
    cnt_d  = cnt_q;
    mrow_d = mrow_q;
    mcol_d = mcol_q;
    if (pop_o) begin
      cnt_d = '0;
    end else if (state_q == BK_DIV) begin
      cnt_d  = cnt_q + 2'd1;
      mrow_d = '0;
      mcol_d = '0;
    end else if (mac_en) begin
      if (mcol_q == 2'(NumAxes - 1)) begin
        mcol_d = '0;
        mrow_d = mrow_q + 2'd1;
      end else begin
        mcol_d = mcol_q + 2'd1;
      end
    end
  end

  // Mean: the multiply for one axis overlaps the remainder step of the one before.
  always_comb begin
    sum_mul   = pick_sum(job_q, cnt_q);
    sum_fin   = pick_sum(job_q, cnt_q - 2'd1);
    aoff_mul  = AoffW'(sum_mul) + SumOffset;
    aoff_fin  = AoffW'(sum_fin) + SumOffset;
    prod_d    = aoff_mul * RecipMult;
    quot      = prod_q[RecipShift +: QuotW];
    rem_full  = aoff_fin - AoffW'(quot) * SamplesW;
    rem       = rem_full[RemW-1:0];
    mean      = $signed({1'b0, quot, FracLut[rem]}) - MeanOffset;
    bias_fin  = pick_bias(cfg_i, cnt_q - 2'd1);
    corr_full = mean - MeanW'(bias_fin);
  end

  // Matrix: one coefficient times one corrected axis per cycle.
  always_comb begin
    row_sel  = pick_row(cfg_i, mrow_q);
    coef     = pick_coef(row_sel, mcol_q);
    mac_prod = coef * corr_q[mcol_q];
    acc_d    = ((mcol_q == '0) ? '0 : acc_q) + AccW'(mac_prod);
    rnd      = (acc_q + RoundHalf) >>> RoundShift;
    if (rnd > FieldHi) begin
      fld_d = FieldHi[FieldW-1:0];
    end else if (rnd < FieldLo) begin
      fld_d = FieldLo[FieldW-1:0];
    end else begin
      fld_d = rnd[FieldW-1:0];
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (out_load) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      mrow_q      <= '0;
      mcol_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mrow_q      <= mrow_d;
      mcol_q      <= mcol_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (div_mul) begin
      prod_q <= prod_d;
    end
    if (div_fin) begin
      corr_q[cnt_q - 2'd1] <= corr_full[CorrW-1:0];
    end
    if (mac_en) begin
      acc_q <= acc_d;
    end
    if (res_en) begin
      fld_q[mrow_q - 2'd1] <= fld_d;
    end
    if (out_load) begin
      res_q.time_stamp <= job_q.time_stamp;
      res_q.field_x    <= fld_q[0];
      res_q.field_y    <= fld_q[1];
      res_q.field_z    <= fld_q[2];
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/magnetometer_sample_calibration_unit.sv =====
// Throughput: one input word per cycle while the job queue has room. The back end works on
// one group at a time: it takes the group from the queue, forms the mean of each axis, runs
// the multiply-accumulate of the matrix on the shared multiplier and loads the output register
// once the output is free. While it works the front end fills the queue, and when the queue is
// full the input waits until the back end takes the next group.
// Reset clears the group count, the queue and the output valid and restores the registers.
//
// Top level of the magnetometer calibration unit. It holds the configuration registers
// and joins the three parts of the datapath:
//   - the front end checks every read and keeps the running axis sums,
//   - a two-entry queue carries finished groups and their time stamps,
//   - the back end divides, removes the bias and applies the calibration matrix.
// The front end keeps taking words while the back end works on an earlier group, and the
// back end holds a finished result in its output register, so each side stalls on its own.
// The axis sums are not reset: the first valid sample of every group overwrites them.
// Depends on mcal_pkg, mcal_front, mcal_queue and mcal_back.
module magnetometer_sample_calibration_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input words.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // status_one[7:0], x_low[15:8], x_high[23:16], y_low[31:24], y_high[39:32],
  // z_low[47:40], z_high[55:48], status_two[63:56], capture_time[127:64]
  input  logic [mcal_pkg::DataInW-1:0]  s_axis_tdata_i,
  // transfer_ok[0]
  input  logic                          s_axis_tuser_i,
  // Result words.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // time_stamp[63:0], field_x[92:64], field_y[121:93], field_z[150:122], zero[151]
  output logic [mcal_pkg::DataOutW-1:0] m_axis_tdata_o,
  // Register writes.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [2:0]                    cfg_index_i,
  input  logic [47:0]                   cfg_data_i
);
  import mcal_pkg::*;

  cfg_t    cfg_q, cfg_d;
  job_t    front_job, queue_job;
  result_t res;
  logic    push, queue_full, queue_valid, pop;

  // Registers are always writable; the user must only change them while the unit is idle, the unit does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ORIENT:   cfg_d.orientation = orient_e'(cfg_data_i[2:0]);
        CFG_BIAS_X:   cfg_d.bias[0]     = cfg_data_i[BiasW-1:0];
        CFG_BIAS_Y:   cfg_d.bias[1]     = cfg_data_i[BiasW-1:0];
        CFG_BIAS_Z:   cfg_d.bias[2]     = cfg_data_i[BiasW-1:0];
        CFG_ROW_ZERO: cfg_d.matrix[0]   = cfg_data_i;
        CFG_ROW_ONE:  cfg_d.matrix[1]   = cfg_data_i;
        CFG_ROW_TWO:  cfg_d.matrix[2]   = cfg_data_i;
        default:      ;  // Indexes past the register list are ignored.
      endcase
    end
  end

  // The registers reset to the upright orientation, no bias and the identity matrix.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.orientation <= ORIENT_X_Y_Z;
      cfg_q.bias        <= '0;
      cfg_q.matrix      <= MatrixReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  mcal_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_ok_i       (s_axis_tuser_i),
    .in_data_i     (s_axis_tdata_i),
    .orientation_i (cfg_q.orientation),
    .queue_full_i  (queue_full),
    .push_o        (push),
    .job_o         (front_job)
  );

  mcal_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .full_o  (queue_full),
    .valid_o (queue_valid),
    .pop_i   (pop),
    .job_o   (queue_job)
  );

  mcal_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (queue_valid),
    .job_i       (queue_job),
    .pop_o       (pop),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .res_o       (res)
  );

  // Result word, time stamp in the lowest bits and one spare bit at the top.
  assign m_axis_tdata_o = {1'b0, res.field_z, res.field_y, res.field_x, res.time_stamp};

endmodule
